/* hdl/lcln_pkg.sv */
// Shared types and constants for the Lamport counting lock node.
package lcln_pkg;

	localparam int APB_ADDR_W = 4;

	localparam logic [2:0] CMD_LOCAL_NEED   = 3'd0;
	localparam logic [2:0] CMD_PEER_REQUEST = 3'd1;
	localparam logic [2:0] CMD_ACK          = 3'd2;
	localparam logic [2:0] CMD_TAKEOVER     = 3'd3;
	localparam logic [2:0] CMD_GRAB         = 3'd4;
	localparam logic [2:0] CMD_PEER_RELEASE = 3'd5;

	localparam logic [2:0] MSG_REQUEST  = 3'd0;
	localparam logic [2:0] MSG_ACK      = 3'd1;
	localparam logic [2:0] MSG_TAKEOVER = 3'd2;
	localparam logic [2:0] MSG_ANNOUNCE = 3'd3;
	localparam logic [2:0] MSG_RELEASE  = 3'd4;

	localparam logic [1:0] DEST_PEER      = 2'd0;
	localparam logic [1:0] DEST_PRODUCERS = 2'd1;
	localparam logic [1:0] DEST_CONSUMERS = 2'd2;

	localparam logic [1:0] REG_OWN_RANK   = 2'd0;
	localparam logic [1:0] REG_NODE_COUNT = 2'd1;
	localparam logic [1:0] REG_POOL_SIZE  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVENT = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] msg_clock;
		logic [3:0]  msg_rank;
	} item_t;

	typedef struct packed {
		logic [2:0]  msg_type;
		logic [1:0]  dest_kind;
		logic [3:0]  dest_rank;
		logic [31:0] out_clock;
		logic [7:0]  free_count;
		logic        holding_item;
		logic        awaiting_consumer;
		logic        last;
	} result_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} qop_t;

endpackage

/* hdl/lamport_counting_lock_node.sv */
// Top level of the Lamport counting lock node: sequencer, counters, queue and register port.
//
// Channel   Direction  Handshake              Payload
// item      in         start high, busy low   lcln_pkg::item_t
// result    out        strobe, one cycle      lcln_pkg::result_t
// config    in/out     APB write, pready = 1  own_rank, node_count, pool_size
//
// An item passes through the sequencer's event and grant-check states after acceptance,
// then through the emit state once for each message it causes.
// The event and grant steps each update the queue cells at most once.
// An unknown command returns to idle after the event cycle with no result.
// Reset clears the clock, counters and flags and sets both pool_size and the free count to one.
// Results cannot be held off; busy stays high until the final one has been shown.
module lamport_counting_lock_node #(
	parameter int MAX_NODES  = 16,
	parameter int CLOCK_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  lcln_pkg::item_t                     item,
	output logic                                strobe,
	output lcln_pkg::result_t                   result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lcln_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int FW = $clog2(MAX_NODES + 1);

	lcln_pkg::state_t      state_q;
	logic [2:0]            cmd_q;
	logic [CLOCK_BITS-1:0] mclk_q;
	logic [3:0]            mrank_q;
	logic [3:0]            own_rank_q;
	logic [4:0]            node_count_q;
	logic [7:0]            pool_size_q;
	logic [CLOCK_BITS-1:0] clock_q;
	logic [3:0]            ack_q;
	logic [7:0]            free_q;
	logic                  hold_q;
	logic                  wait_q;
	logic                  ev_valid_q;
	logic [2:0]            ev_type_q;
	logic [3:0]            ev_rank_q;
	logic [CLOCK_BITS-1:0] ev_clk_q;
	logic                  grant_q;
	logic [1:0]            idx_q;

	logic [63:0]           in_wide;
	logic [CLOCK_BITS-1:0] tick_clk;
	logic [CLOCK_BITS-1:0] peer_clk;
	logic [CLOCK_BITS-1:0] sel_clk;
	logic [CLOCK_BITS-1:0] q_new_clk;
	logic [3:0]            q_new_rank;
	logic [3:0]            q_head_rank;
	logic [FW-1:0]         q_fill;
	lcln_pkg::qop_t        q_op;
	logic                  grant_w;
	logic                  cfg_wr;
	logic [1:0]            total;
	logic [1:0]            gpos;

	assign in_wide  = 64'(item.msg_clock);
	assign tick_clk = clock_q + CLOCK_BITS'(1);
	assign peer_clk = ((mclk_q > clock_q) ? mclk_q : clock_q) + CLOCK_BITS'(1);

	assign grant_w = hold_q && (q_fill != '0) && (q_head_rank == own_rank_q) &&
		(node_count_q != 5'd0) && ({1'b0, ack_q} == (node_count_q - 5'd1)) && (free_q != 8'd0);

	always_comb begin
		q_op.insert = 1'b0;
		q_op.pop    = 1'b0;
		q_new_clk   = mclk_q;
		q_new_rank  = mrank_q;
		if (state_q == lcln_pkg::ST_EVENT) begin
			case (cmd_q)
				lcln_pkg::CMD_LOCAL_NEED: begin
					q_op.insert = 1'b1;
					q_new_clk   = tick_clk;
					q_new_rank  = own_rank_q;
				end
				lcln_pkg::CMD_PEER_REQUEST: begin
					q_op.insert = 1'b1;
				end
				lcln_pkg::CMD_TAKEOVER: begin
					q_op.pop = 1'b1;
				end
				default: begin
					q_op.insert = 1'b0;
				end
			endcase
		end else if (state_q == lcln_pkg::ST_CHECK) begin
			q_op.pop = grant_w;
		end
	end

	lcln_queue #(
		.MAX_NODES (MAX_NODES),
		.CLOCK_BITS(CLOCK_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (q_op),
		.new_clk  (q_new_clk),
		.new_rank (q_new_rank),
		.head_rank(q_head_rank),
		.fill     (q_fill)
	);

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lcln_pkg::ST_IDLE;
			own_rank_q   <= 4'd0;
			node_count_q <= 5'd2;
			pool_size_q  <= 8'd1;
			clock_q      <= '0;
			ack_q        <= 4'd0;
			free_q       <= 8'd1;
			hold_q       <= 1'b0;
			wait_q       <= 1'b0;
			ev_valid_q   <= 1'b0;
			grant_q      <= 1'b0;
			idx_q        <= 2'd0;
		end else begin
			case (state_q)
				lcln_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= lcln_pkg::ST_EVENT;
					end
				end
				lcln_pkg::ST_EVENT: begin
					ev_valid_q <= (cmd_q == lcln_pkg::CMD_LOCAL_NEED) ||
						(cmd_q == lcln_pkg::CMD_PEER_REQUEST) || (cmd_q == lcln_pkg::CMD_GRAB);
					case (cmd_q)
						lcln_pkg::CMD_LOCAL_NEED: begin
							state_q <= lcln_pkg::ST_CHECK;
							hold_q  <= 1'b1;
							clock_q <= tick_clk;
						end
						lcln_pkg::CMD_PEER_REQUEST: begin
							state_q <= lcln_pkg::ST_CHECK;
							clock_q <= peer_clk;
						end
						lcln_pkg::CMD_ACK: begin
							state_q <= lcln_pkg::ST_CHECK;
							if (ack_q != 4'd15) begin
								ack_q <= ack_q + 4'd1;
							end
						end
						lcln_pkg::CMD_TAKEOVER: begin
							state_q <= lcln_pkg::ST_CHECK;
							if (free_q != 8'd0) begin
								free_q <= free_q - 8'd1;
							end
						end
						lcln_pkg::CMD_GRAB: begin
							state_q <= lcln_pkg::ST_CHECK;
							wait_q  <= 1'b0;
							hold_q  <= 1'b0;
							clock_q <= tick_clk;
							if (free_q != 8'd255) begin
								free_q <= free_q + 8'd1;
							end
						end
						lcln_pkg::CMD_PEER_RELEASE: begin
							state_q <= lcln_pkg::ST_CHECK;
							if (free_q != 8'd255) begin
								free_q <= free_q + 8'd1;
							end
						end
						default: begin
							state_q <= lcln_pkg::ST_IDLE;
						end
					endcase
				end
				lcln_pkg::ST_CHECK: begin
					grant_q <= grant_w;
					idx_q   <= 2'd0;
					if (grant_w) begin
						ack_q   <= 4'd0;
						clock_q <= tick_clk;
						wait_q  <= 1'b1;
						if (free_q != 8'd0) begin
							free_q <= free_q - 8'd1;
						end
					end
					if (grant_w || ev_valid_q) begin
						state_q <= lcln_pkg::ST_EMIT;
					end else begin
						state_q <= lcln_pkg::ST_IDLE;
					end
				end
				lcln_pkg::ST_EMIT: begin
					idx_q <= idx_q + 2'd1;
					if (result.last) begin
						state_q <= lcln_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lcln_pkg::ST_IDLE;
				end
			endcase

			if (cfg_wr) begin
				case (paddr[3:2])
					lcln_pkg::REG_OWN_RANK: begin
						own_rank_q <= pwdata[3:0];
					end
					lcln_pkg::REG_NODE_COUNT: begin
						node_count_q <= pwdata[4:0];
					end
					lcln_pkg::REG_POOL_SIZE: begin
						pool_size_q <= pwdata[7:0];
						free_q      <= pwdata[7:0];
					end
					default: begin
						pool_size_q <= pool_size_q;
					end
				endcase
			end
		end
	end

	// Item payload and the event message are held in registers without reset.
	always_ff @(posedge clk) begin
		if ((state_q == lcln_pkg::ST_IDLE) && start) begin
			cmd_q   <= item.command;
			mclk_q  <= in_wide[CLOCK_BITS-1:0];
			mrank_q <= item.msg_rank;
		end
		if (state_q == lcln_pkg::ST_EVENT) begin
			case (cmd_q)
				lcln_pkg::CMD_LOCAL_NEED: begin
					ev_type_q <= lcln_pkg::MSG_REQUEST;
					ev_rank_q <= 4'd0;
					ev_clk_q  <= tick_clk;
				end
				lcln_pkg::CMD_PEER_REQUEST: begin
					ev_type_q <= lcln_pkg::MSG_ACK;
					ev_rank_q <= mrank_q;
					ev_clk_q  <= peer_clk;
				end
				default: begin
					ev_type_q <= lcln_pkg::MSG_RELEASE;
					ev_rank_q <= 4'd0;
					ev_clk_q  <= tick_clk;
				end
			endcase
		end
	end

	assign total = {grant_q, 1'b0} + {1'b0, ev_valid_q};
	assign gpos  = idx_q - {1'b0, ev_valid_q};

	always_comb begin
		if (ev_valid_q && (idx_q == 2'd0)) begin
			result.msg_type  = ev_type_q;
			result.dest_kind = (ev_type_q == lcln_pkg::MSG_ACK) ? lcln_pkg::DEST_PEER
				: lcln_pkg::DEST_PRODUCERS;
			result.dest_rank = ev_rank_q;
			sel_clk          = ev_clk_q;
		end else if (gpos == 2'd0) begin
			result.msg_type  = lcln_pkg::MSG_TAKEOVER;
			result.dest_kind = lcln_pkg::DEST_PRODUCERS;
			result.dest_rank = 4'd0;
			sel_clk          = clock_q;
		end else begin
			result.msg_type  = lcln_pkg::MSG_ANNOUNCE;
			result.dest_kind = lcln_pkg::DEST_CONSUMERS;
			result.dest_rank = 4'd0;
			sel_clk          = clock_q;
		end
		result.out_clock         = 32'(sel_clk);
		result.free_count        = free_q;
		result.holding_item      = hold_q;
		result.awaiting_consumer = wait_q;
		result.last              = (idx_q == (total - 2'd1));
	end

	assign strobe = (state_q == lcln_pkg::ST_EMIT);
	assign busy   = (state_q != lcln_pkg::ST_IDLE);
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			lcln_pkg::REG_OWN_RANK:   prdata = {28'd0, own_rank_q};
			lcln_pkg::REG_NODE_COUNT: prdata = {27'd0, node_count_q};
			lcln_pkg::REG_POOL_SIZE:  prdata = {24'd0, pool_size_q};
			default:                  prdata = 32'd0;
		endcase
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result shown while the node is idle");

	a_grant_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == lcln_pkg::ST_CHECK) && grant_w) |-> (q_fill != '0))
		else $error("grant on an empty request queue");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !busy)
		else $error("node still busy after the final result");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill <= FW'(MAX_NODES))
		else $error("queue fill beyond its depth");

	a_grant_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == lcln_pkg::ST_CHECK) && grant_w) |=> ((ack_q == 4'd0) && wait_q))
		else $error("grant did not clear the ack count and set the wait flag");

endmodule

/* hdl/lcln_cell.sv */
// One cell of the sorted request queue: holds one entry and shifts with its neighbors.
module lcln_cell #(
	parameter int CLOCK_BITS = 32
) (
	input  logic                  clk,
	input  lcln_pkg::qop_t        op,
	input  logic [CLOCK_BITS-1:0] new_clk,
	input  logic [3:0]            new_rank,
	input  logic                  below_fill,
	input  logic                  at_fill,
	input  logic [CLOCK_BITS-1:0] left_clk,
	input  logic [3:0]            left_rank,
	input  logic                  left_gt,
	input  logic [CLOCK_BITS-1:0] right_clk,
	input  logic [3:0]            right_rank,
	output logic [CLOCK_BITS-1:0] entry_clk,
	output logic [3:0]            entry_rank,
	output logic                  gt
);

	logic [CLOCK_BITS-1:0] clk_q;
	logic [3:0]            rank_q;

	// The cell's entry orders after the new request.
	assign gt = below_fill && ((new_clk < clk_q) || ((new_clk == clk_q) && (new_rank < rank_q)));

	always_ff @(posedge clk) begin
		if (op.pop) begin
			clk_q  <= right_clk;
			rank_q <= right_rank;
		end else if (op.insert) begin
			if (left_gt) begin
				clk_q  <= left_clk;
				rank_q <= left_rank;
			end else if (gt || at_fill) begin
				clk_q  <= new_clk;
				rank_q <= new_rank;
			end
		end
	end

	assign entry_clk  = clk_q;
	assign entry_rank = rank_q;

endmodule

/* hdl/lcln_queue.sv */
// Request queue sorted by clock and rank, built as a row of cells with a fill count.
module lcln_queue #(
	parameter int MAX_NODES  = 16,
	parameter int CLOCK_BITS = 32,
	localparam int FW = $clog2(MAX_NODES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcln_pkg::qop_t        op,
	input  logic [CLOCK_BITS-1:0] new_clk,
	input  logic [3:0]            new_rank,
	output logic [3:0]            head_rank,
	output logic [FW-1:0]         fill
);

	logic [FW-1:0]         fill_q;
	logic                  full;
	lcln_pkg::qop_t        cell_op;
	logic [CLOCK_BITS-1:0] ent_clk [MAX_NODES];
	logic [3:0]            ent_rank [MAX_NODES];
	logic                  ent_gt [MAX_NODES];

	assign full = (fill_q == FW'(MAX_NODES));

	always_comb begin
		cell_op.insert = op.insert && !full;
		cell_op.pop    = op.pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cell_op.insert) begin
			fill_q <= fill_q + FW'(1);
		end else if (op.pop && (fill_q != '0)) begin
			fill_q <= fill_q - FW'(1);
		end
	end

	for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
		logic [CLOCK_BITS-1:0] l_clk;
		logic [3:0]            l_rank;
		logic                  l_gt;
		logic [CLOCK_BITS-1:0] r_clk;
		logic [3:0]            r_rank;

		if (i == 0) begin : g_first
			assign l_clk  = new_clk;
			assign l_rank = new_rank;
			assign l_gt   = 1'b0;
		end else begin : g_mid
			assign l_clk  = ent_clk[i-1];
			assign l_rank = ent_rank[i-1];
			assign l_gt   = ent_gt[i-1];
		end

		if (i == MAX_NODES - 1) begin : g_last
			assign r_clk  = ent_clk[i];
			assign r_rank = ent_rank[i];
		end else begin : g_inner
			assign r_clk  = ent_clk[i+1];
			assign r_rank = ent_rank[i+1];
		end

		lcln_cell #(
			.CLOCK_BITS(CLOCK_BITS)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.new_clk   (new_clk),
			.new_rank  (new_rank),
			.below_fill(FW'(i) < fill_q),
			.at_fill   (FW'(i) == fill_q),
			.left_clk  (l_clk),
			.left_rank (l_rank),
			.left_gt   (l_gt),
			.right_clk (r_clk),
			.right_rank(r_rank),
			.entry_clk (ent_clk[i]),
			.entry_rank(ent_rank[i]),
			.gt        (ent_gt[i])
		);
	end

	assign head_rank = ent_rank[0];
	assign fill      = fill_q;

endmodule

/* tb/lcln_msg_checker.sv */
// Checker for the Lamport counting lock node: predicts every message from accepted items and compares.
module lcln_msg_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  lcln_pkg::item_t                 item,
	input  logic                            strobe,
	input  lcln_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [lcln_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output int                              mismatches,
	output int                              msgs_left,
	output logic [3:0]                      ack_level
);

	localparam int DEPTH = 16;

	logic [31:0]       lamport;
	logic [31:0]       req_clk [DEPTH];
	logic [3:0]        req_rank [DEPTH];
	int                req_fill;
	logic [3:0]        acks;
	logic [7:0]        free_res;
	logic              holding;
	logic              waiting;
	logic [3:0]        own_rank;
	logic [4:0]        node_count;
	lcln_pkg::result_t msgs_due [$];

	assign ack_level = acks;

	function automatic lcln_pkg::result_t make_msg(input logic [2:0] kind,
			input logic [1:0] dest, input logic [3:0] rank, input logic [31:0] stamp);
		lcln_pkg::result_t m;
		m = '0;
		m.msg_type = kind;
		m.dest_kind = dest;
		m.dest_rank = rank;
		m.out_clock = stamp;
		return m;
	endfunction

	// The queue stays sorted by stamp, with the lower rank first on equal stamps.
	task automatic enqueue_request(input logic [31:0] stamp, input logic [3:0] rank);
		int pos;
		if (req_fill >= DEPTH)
			return;
		pos = req_fill;
		while (pos > 0 && (stamp < req_clk[pos-1] ||
				(stamp == req_clk[pos-1] && rank < req_rank[pos-1]))) begin
			req_clk[pos] = req_clk[pos-1];
			req_rank[pos] = req_rank[pos-1];
			pos--;
		end
		req_clk[pos] = stamp;
		req_rank[pos] = rank;
		req_fill++;
	endtask

	task automatic drop_head();
		int i;
		if (req_fill == 0)
			return;
		for (i = 0; i < req_fill - 1; i++) begin
			req_clk[i] = req_clk[i+1];
			req_rank[i] = req_rank[i+1];
		end
		req_fill--;
	endtask

	task automatic apply_event(input lcln_pkg::item_t it);
		lcln_pkg::result_t m [3];
		int n;
		int k;
		n = 0;
		case (it.command)
		lcln_pkg::CMD_LOCAL_NEED: begin
			holding = 1'b1;
			lamport = lamport + 32'd1;
			enqueue_request(lamport, own_rank);
			m[n] = make_msg(lcln_pkg::MSG_REQUEST, lcln_pkg::DEST_PRODUCERS, 4'd0, lamport);
			n++;
		end
		lcln_pkg::CMD_PEER_REQUEST: begin
			enqueue_request(it.msg_clock, it.msg_rank);
			if (it.msg_clock > lamport)
				lamport = it.msg_clock;
			lamport = lamport + 32'd1;
			m[n] = make_msg(lcln_pkg::MSG_ACK, lcln_pkg::DEST_PEER, it.msg_rank, lamport);
			n++;
		end
		lcln_pkg::CMD_ACK: begin
			if (acks != 4'd15)
				acks = acks + 4'd1;
		end
		lcln_pkg::CMD_TAKEOVER: begin
			if (free_res != 8'd0)
				free_res = free_res - 8'd1;
			drop_head();
		end
		lcln_pkg::CMD_GRAB: begin
			waiting = 1'b0;
			holding = 1'b0;
			lamport = lamport + 32'd1;
			if (free_res != 8'd255)
				free_res = free_res + 8'd1;
			m[n] = make_msg(lcln_pkg::MSG_RELEASE, lcln_pkg::DEST_PRODUCERS, 4'd0, lamport);
			n++;
		end
		lcln_pkg::CMD_PEER_RELEASE: begin
			if (free_res != 8'd255)
				free_res = free_res + 8'd1;
		end
		default: begin
			return;
		end
		endcase

		if (holding && req_fill > 0 && req_rank[0] == own_rank && node_count != 5'd0 &&
				int'(acks) == int'(node_count) - 1 && free_res != 8'd0) begin
			acks = 4'd0;
			lamport = lamport + 32'd1;
			drop_head();
			free_res = free_res - 8'd1;
			waiting = 1'b1;
			m[n] = make_msg(lcln_pkg::MSG_TAKEOVER, lcln_pkg::DEST_PRODUCERS, 4'd0, lamport);
			n++;
			m[n] = make_msg(lcln_pkg::MSG_ANNOUNCE, lcln_pkg::DEST_CONSUMERS, 4'd0, lamport);
			n++;
		end

		for (k = 0; k < n; k++) begin
			m[k].free_count = free_res;
			m[k].holding_item = holding;
			m[k].awaiting_consumer = waiting;
			m[k].last = (k == n - 1);
			msgs_due = {msgs_due, m[k]};
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcln_pkg::result_t due;
		if (!arst_n) begin
			lamport = '0;
			req_fill = 0;
			acks = '0;
			holding = 1'b0;
			waiting = 1'b0;
			own_rank = '0;
			node_count = 5'd2;
			free_res = 8'd1;
			msgs_due.delete();
			mismatches = 0;
			msgs_left = 0;
		end else begin
			if (strobe) begin
				if (msgs_due.size() == 0) begin
					$error("message with no expectation pending: msg_type %0d out_clock %0h",
						result.msg_type, result.out_clock);
					mismatches++;
				end else begin
					due = msgs_due.pop_front();
					check_field("msg_type", 32'(due.msg_type), 32'(result.msg_type));
					check_field("dest_kind", 32'(due.dest_kind), 32'(result.dest_kind));
					check_field("dest_rank", 32'(due.dest_rank), 32'(result.dest_rank));
					check_field("out_clock", due.out_clock, result.out_clock);
					check_field("free_count", 32'(due.free_count), 32'(result.free_count));
					check_field("holding_item", 32'(due.holding_item),
						32'(result.holding_item));
					check_field("awaiting_consumer", 32'(due.awaiting_consumer),
						32'(result.awaiting_consumer));
					check_field("last", 32'(due.last), 32'(result.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
				lcln_pkg::REG_OWN_RANK: begin
					own_rank = pwdata[3:0];
				end
				lcln_pkg::REG_NODE_COUNT: begin
					node_count = pwdata[4:0];
				end
				lcln_pkg::REG_POOL_SIZE: begin
					free_res = pwdata[7:0];
				end
				default: begin
				end
				endcase
			end
			if (start && !busy)
				apply_event(item);
			msgs_left = msgs_due.size();
		end
	end

endmodule

/* tb/tb_lamport_counting_lock_node.sv */
// Regression top for the Lamport counting lock node: clock, reset, stimulus and verdict.
module tb_lamport_counting_lock_node;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_EVENTS = 100;
	localparam int DEPTH_FLOOD = 17;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	lcln_pkg::item_t                 item;
	logic                            strobe;
	lcln_pkg::result_t               result;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [lcln_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;
	int                              mismatches;
	int                              msgs_left;
	logic [3:0]                      ack_level;

	int cycles = 0;
	int events_sent = 0;
	int cur_nodes = 2;
	bit gaps_on = 1'b1;

	lamport_counting_lock_node uut (
		.clk, .arst_n, .start, .busy, .item, .strobe, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	lcln_msg_checker msg_chk (
		.clk, .arst_n, .start, .busy, .item, .strobe, .result,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.mismatches, .msgs_left, .ack_level
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lamport_counting_lock_node regression: fail");
			$finish;
		end
	end

	function automatic logic [31:0] rand_stamp();
		case ($urandom_range(0, 3))
		0: return $urandom;
		1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
		default: return $urandom_range(0, 300);
		endcase
	endfunction

	function automatic logic [3:0] rand_rank();
		return 4'($urandom_range(0, 15));
	endfunction

	// All tasks below are entered and left just after a falling edge.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {index, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (index == lcln_pkg::REG_NODE_COUNT)
			cur_nodes = int'(value[4:0]);
	endtask

	// Start stays high after acceptance until the next item or the next settle.
	task automatic send_event(input logic [2:0] cmd, input logic [31:0] stamp,
			input logic [3:0] rank);
		if (gaps_on && $urandom_range(0, 99) < 16) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start = 1'b1;
		item = '{command: cmd, msg_clock: stamp, msg_rank: rank};
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		if (cmd <= lcln_pkg::CMD_PEER_RELEASE)
			events_sent++;
	endtask

	task automatic settle();
		start = 1'b0;
		while (msgs_left != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic configure(input logic [3:0] rank, input int nodes, input logic [7:0] pool);
		settle();
		write_reg(lcln_pkg::REG_OWN_RANK, 32'(rank));
		write_reg(lcln_pkg::REG_NODE_COUNT, 32'(nodes));
		write_reg(lcln_pkg::REG_POOL_SIZE, 32'(pool));
	endtask

	// A well-formed round: request, enough acknowledgements for a grant, then the hand-off.
	task automatic run_episode();
		int need;
		repeat ($urandom_range(0, 2))
			send_event(lcln_pkg::CMD_PEER_REQUEST, rand_stamp(), rand_rank());
		send_event(lcln_pkg::CMD_LOCAL_NEED, rand_stamp(), rand_rank());
		need = cur_nodes - 1 - int'(ack_level);
		repeat (need > 0 ? need : 0)
			send_event(lcln_pkg::CMD_ACK, rand_stamp(), rand_rank());
		repeat ($urandom_range(0, 2))
			send_event(lcln_pkg::CMD_TAKEOVER, rand_stamp(), rand_rank());
		repeat ($urandom_range(0, 2))
			send_event(lcln_pkg::CMD_PEER_RELEASE, rand_stamp(), rand_rank());
		send_event(lcln_pkg::CMD_GRAB, rand_stamp(), rand_rank());
	endtask

	// Acknowledgements past the quorum would block grants for good, so they are held back.
	task automatic run_noise();
		logic [2:0] cmd;
		repeat ($urandom_range(1, 4)) begin
			cmd = 3'($urandom_range(0, 7));
			if (cmd == lcln_pkg::CMD_ACK && int'(ack_level) >= cur_nodes - 1)
				cmd = lcln_pkg::CMD_PEER_RELEASE;
			send_event(cmd, $urandom, rand_rank());
		end
	endtask

	task automatic run_flood();
		repeat (DEPTH_FLOOD)
			send_event(lcln_pkg::CMD_PEER_REQUEST, rand_stamp(), rand_rank());
		repeat (DEPTH_FLOOD)
			send_event(lcln_pkg::CMD_TAKEOVER, rand_stamp(), rand_rank());
		repeat (3) send_event(lcln_pkg::CMD_PEER_RELEASE, rand_stamp(), rand_rank());
	endtask

	initial begin
		int target;
		int lo;
		int pick;
		int p;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single producer, full pool: grants come straight from a local need.
		configure(4'd15, 1, 8'd255);
		send_event(lcln_pkg::CMD_PEER_RELEASE, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_LOCAL_NEED, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_GRAB, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_PEER_REQUEST, 32'hFFFF_FFFF, 4'd15);
		send_event(lcln_pkg::CMD_LOCAL_NEED, 32'hFFFF_FFFF, 4'd15);
		send_event(lcln_pkg::CMD_TAKEOVER, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_TAKEOVER, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_ACK, 32'd0, 4'd0);
		send_event(3'd6, 32'hFFFF_FFFF, 4'd15);
		send_event(3'd7, 32'hFFFF_FFFF, 4'd15);
		send_event(lcln_pkg::CMD_GRAB, 32'hFFFF_FFFF, 4'd15);

		// No producers and an empty pool: nothing may be granted.
		configure(4'd0, 0, 8'd0);
		send_event(lcln_pkg::CMD_LOCAL_NEED, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_PEER_REQUEST, 32'd0, 4'd15);
		send_event(lcln_pkg::CMD_ACK, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_TAKEOVER, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_PEER_RELEASE, 32'd0, 4'd0);
		send_event(lcln_pkg::CMD_GRAB, 32'd0, 4'd0);

		for (p = 0; p < 5; p++) begin
			lo = int'(ack_level) + 1;
			gaps_on = (p != 2);
			case (p)
			0: configure(rand_rank(), int'($urandom_range(lo, 16)), 8'($urandom_range(1, 8)));
			1: configure(rand_rank(), 16, 8'($urandom_range(0, 255)));
			2: configure(rand_rank(), lo, 8'd0);
			3: configure(rand_rank(), int'($urandom_range(lo, 16)), 8'd255);
			default: configure(rand_rank(), int'($urandom_range(lo, 16)),
				8'($urandom_range(0, 3)));
			endcase
			target = events_sent + PHASE_EVENTS;
			while (events_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					run_episode();
				else if (pick < 95)
					run_noise();
				else
					run_flood();
			end
		end

		settle();
		if (mismatches == 0 && msgs_left == 0) begin
			$display("lamport_counting_lock_node regression: pass");
		end else begin
			$display("lamport_counting_lock_node regression: fail");
		end
		$finish;
	end

endmodule
